// ===== rtl/core/ndlcag_pkg.sv =====
// ----------------------------------------------------------------------------
// ndlcag_pkg
// Shared widths, register indexes, layout codes and defaults of the N-dimensional
// layout copy address generator.
// ----------------------------------------------------------------------------
package ndlcag_pkg;

  localparam int unsigned MAX_DIMS_DEF    = 4;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  localparam int unsigned EXT_REGS   = 4;
  localparam int unsigned EXT_W      = 16;
  localparam int unsigned DIMS_W     = 3;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_DIM3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_LAYOUT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DST_LAYOUT  = 3'd6;

  localparam logic       LAYOUT_FIRST = 1'b0;
  localparam logic       LAYOUT_LAST  = 1'b1;
  localparam logic [1:0] DST_FIRST    = 2'd0;
  localparam logic [1:0] DST_LAST     = 2'd1;
  localparam logic [1:0] DST_SAME     = 2'd2;

  localparam logic [DIMS_W-1:0] DIMS_RESET   = 3'd2;
  localparam logic [EXT_W-1:0]  EXTENT_RESET = 16'd1;

endpackage

// ===== rtl/core/nd_layout_copy_address_gen_top.sv =====
// ----------------------------------------------------------------------------
// nd_layout_copy_address_gen_top
// Generates source and destination element offsets for copying an array of up
// to four dimensions between first-dimension-fastest and last-dimension-fastest
// layouts.
// ----------------------------------------------------------------------------
// One offset pair is produced per accepted beat, and a new beat is taken every
// cycle while the output register is free or being drained. After reset and
// after every write to a known register the block walks each supported
// dimension (at most four) in a prefix, a suffix and a delta pass, deriving
// strides and carry deltas with one shared saturating multiplier, and in_ready_o
// stays low meanwhile. A step needs only per-dimension compares and one add per
// offset, as the carry delta for every dimension is prepared during that
// derivation.
module nd_layout_copy_address_gen_top import ndlcag_pkg::*; #(
  parameter int unsigned MAX_DIMS    = MAX_DIMS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_W-1:0]      src_offset_o,
  output logic [OUT_W-1:0]      dst_offset_o,
  output logic                  last_o,
  output logic                  bad_config_o
);

  localparam int unsigned NDIM = (MAX_DIMS < EXT_REGS) ? MAX_DIMS : EXT_REGS;
  localparam int unsigned IW   = (NDIM > 1) ? $clog2(NDIM) : 1;
  localparam int unsigned AW   = $clog2(NDIM + 1);
  localparam int unsigned OB   = OFFSET_BITS;
  localparam int unsigned SW   = OB + 1;
  localparam int unsigned PW   = SW + EXT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NDIM - 1);
  localparam logic [SW-1:0] LIMIT    = SW'(1) << OB;

  typedef enum logic [1:0] {ST_PRE, ST_SUF, ST_DELTA, ST_RUN} state_e;

  state_e state_q;
  logic [IW-1:0] cnt_q;

  logic [DIMS_W-1:0] dims_q;
  logic [EXT_W-1:0]  ext_q [NDIM];
  logic              src_layout_q;
  logic [1:0]        dst_layout_q;

  logic [SW-1:0] pre_run_q, suf_run_q;
  logic          zero_q, bad_q;
  logic [OB-1:0] pf_q [NDIM];
  logic [OB-1:0] pfw_q [NDIM];
  logic [OB-1:0] sl_q [NDIM];
  logic [OB-1:0] slw_q [NDIM];
  logic [OB-1:0] dsrc_q [NDIM];
  logic [OB-1:0] ddst_q [NDIM];
  logic [OB-1:0] s_src_q, w_src_q, s_dst_q, w_dst_q;

  logic [EXT_W-1:0] coord_q [NDIM];
  logic [OB-1:0]    src_pos_q, dst_pos_q;

  logic             out_valid_q, last_q, bad_out_q;
  logic [OUT_W-1:0] src_off_q, dst_off_q;

  logic cfg_hit, in_fire, dl;
  logic [AW-1:0] act;

  assign cfg_hit = cfg_we_i && (cfg_index_i <= REG_DST_LAYOUT);
  assign dl      = (dst_layout_q >= DST_SAME) ? src_layout_q : dst_layout_q[0];

  always_comb begin
    if (dims_q == '0) begin
      act = AW'(1);
    end else if (dims_q > NDIM) begin
      act = AW'(NDIM);
    end else begin
      act = AW'(dims_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q       <= DIMS_RESET;
      src_layout_q <= LAYOUT_FIRST;
      dst_layout_q <= DST_SAME;
      for (int k = 0; k < NDIM; k++) begin
        ext_q[k] <= EXTENT_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DIMS_IN_USE: dims_q       <= cfg_data_i[DIMS_W-1:0];
        REG_SRC_LAYOUT:  src_layout_q <= cfg_data_i[0];
        REG_DST_LAYOUT:  dst_layout_q <= cfg_data_i[1:0];
        default: begin
          for (int k = 0; k < NDIM; k++) begin
            if (cfg_index_i == REG_EXTENT_DIM0 + CFG_IDX_W'(k)) begin
              ext_q[k] <= cfg_data_i[EXT_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PRE;
      cnt_q   <= '0;
    end else if (cfg_hit) begin
      state_q <= ST_PRE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_PRE: begin
          cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
          if (cnt_q == LAST_IDX) state_q <= ST_SUF;
        end
        ST_SUF: begin
          cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
          if (cnt_q == LAST_IDX) state_q <= ST_DELTA;
        end
        ST_DELTA: begin
          cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IW'(1);
          if (cnt_q == LAST_IDX) state_q <= ST_RUN;
        end
        ST_RUN: state_q <= ST_RUN;
        default: state_q <= ST_PRE;
      endcase
    end
  end

  logic [IW-1:0]    rev_idx, sel_idx;
  logic [EXT_W-1:0] ext_sel;
  logic             sel_active, zero_n;
  logic [SW-1:0]    mul_a, mul_sat, mul_next;
  logic [PW-1:0]    mul_p;

  assign rev_idx    = LAST_IDX - cnt_q;
  assign sel_idx    = (state_q == ST_PRE) ? cnt_q : rev_idx;
  assign ext_sel    = ext_q[sel_idx];
  assign sel_active = AW'(sel_idx) < act;
  assign mul_a      = (cnt_q == '0) ? SW'(1) :
                      ((state_q == ST_PRE) ? pre_run_q : suf_run_q);
  assign mul_p      = PW'(mul_a) * PW'(ext_sel);
  assign mul_sat    = (mul_p > PW'(LIMIT)) ? LIMIT + SW'(1) : mul_p[SW-1:0];
  assign mul_next   = sel_active ? mul_sat : mul_a;
  assign zero_n     = ((cnt_q == '0) ? 1'b0 : zero_q) || (sel_active && ext_sel == '0);

  logic [OB-1:0] st_src, wr_src, st_dst, wr_dst;
  logic [OB-1:0] s_src_b, w_src_b, s_dst_b, w_dst_b;
  logic [OB-1:0] s_src_n, w_src_n, s_dst_n, w_dst_n, d_src_n, d_dst_n;

  assign st_src  = (src_layout_q == LAYOUT_FIRST) ? pf_q[rev_idx]  : sl_q[rev_idx];
  assign wr_src  = (src_layout_q == LAYOUT_FIRST) ? pfw_q[rev_idx] : slw_q[rev_idx];
  assign st_dst  = (dl == LAYOUT_FIRST) ? pf_q[rev_idx]  : sl_q[rev_idx];
  assign wr_dst  = (dl == LAYOUT_FIRST) ? pfw_q[rev_idx] : slw_q[rev_idx];
  assign s_src_b = (cnt_q == '0) ? '0 : s_src_q;
  assign w_src_b = (cnt_q == '0) ? '0 : w_src_q;
  assign s_dst_b = (cnt_q == '0) ? '0 : s_dst_q;
  assign w_dst_b = (cnt_q == '0) ? '0 : w_dst_q;
  assign s_src_n = s_src_b + st_src;
  assign d_src_n = s_src_n - w_src_b;
  assign w_src_n = w_src_b + wr_src;
  assign s_dst_n = s_dst_b + st_dst;
  assign d_dst_n = s_dst_n - w_dst_b;
  assign w_dst_n = w_dst_b + wr_dst;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PRE: begin
        pre_run_q     <= mul_next;
        zero_q        <= zero_n;
        pf_q[cnt_q]   <= mul_a[OB-1:0];
        pfw_q[cnt_q]  <= mul_next[OB-1:0];
        if (cnt_q == LAST_IDX) begin
          bad_q <= zero_n || (mul_next > LIMIT);
        end
      end
      ST_SUF: begin
        suf_run_q      <= mul_next;
        sl_q[rev_idx]  <= mul_a[OB-1:0];
        slw_q[rev_idx] <= mul_next[OB-1:0];
      end
      ST_DELTA: begin
        s_src_q <= sel_active ? s_src_n : '0;
        w_src_q <= sel_active ? w_src_n : '0;
        s_dst_q <= sel_active ? s_dst_n : '0;
        w_dst_q <= sel_active ? w_dst_n : '0;
        dsrc_q[rev_idx] <= d_src_n;
        ddst_q[rev_idx] <= d_dst_n;
      end
      default: begin
      end
    endcase
  end

  logic [EXT_W-1:0] eff_coord [NDIM];
  logic [EXT_W-1:0] nxt_coord [NDIM];
  logic [NDIM-1:0]  at_max;
  logic [IW-1:0]    step_j;
  logic             step_last;
  logic [OB-1:0]    eff_src, eff_dst, nxt_src, nxt_dst;

  always_comb begin
    step_j    = '0;
    step_last = 1'b1;
    for (int i = 0; i < NDIM; i++) begin
      eff_coord[i] = restart_i ? '0 : coord_q[i];
      at_max[i]    = eff_coord[i] == ext_q[i] - EXT_W'(1);
      if (AW'(i) < act && !at_max[i]) begin
        step_j    = IW'(i);
        step_last = 1'b0;
      end
    end
    for (int i = 0; i < NDIM; i++) begin
      if (step_last || (IW'(i) > step_j && AW'(i) < act)) begin
        nxt_coord[i] = '0;
      end else if (IW'(i) == step_j) begin
        nxt_coord[i] = eff_coord[i] + EXT_W'(1);
      end else begin
        nxt_coord[i] = eff_coord[i];
      end
    end
  end

  assign eff_src = restart_i ? '0 : src_pos_q;
  assign eff_dst = restart_i ? '0 : dst_pos_q;
  assign nxt_src = step_last ? '0 : eff_src + dsrc_q[step_j];
  assign nxt_dst = step_last ? '0 : eff_dst + ddst_q[step_j];

  assign in_ready_o = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_pos_q <= '0;
      dst_pos_q <= '0;
      for (int i = 0; i < NDIM; i++) begin
        coord_q[i] <= '0;
      end
    end else if (state_q != ST_RUN) begin
      src_pos_q <= '0;
      dst_pos_q <= '0;
      for (int i = 0; i < NDIM; i++) begin
        coord_q[i] <= '0;
      end
    end else if (in_fire && !bad_q) begin
      src_pos_q <= nxt_src;
      dst_pos_q <= nxt_dst;
      coord_q   <= nxt_coord;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      src_off_q <= bad_q ? '0 : OUT_W'(eff_src);
      dst_off_q <= bad_q ? '0 : OUT_W'(eff_dst);
      last_q    <= !bad_q && step_last;
      bad_out_q <= bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign src_offset_o = src_off_q;
  assign dst_offset_o = dst_off_q;
  assign last_o       = last_q;
  assign bad_config_o = bad_out_q;

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> !in_ready_o)
    else $error("Input accepted while strides are being derived.");

  a_bad_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_config_o |-> src_offset_o == '0 && dst_offset_o == '0 && !last_o)
    else $error("Unusable configuration produced a non-zero result.");

  a_last_wraps_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !bad_q && step_last && !cfg_hit |=> src_pos_q == '0 && dst_pos_q == '0)
    else $error("Walk did not return to the origin after the final element.");

endmodule
